// ===== hw/rtl/sbhp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbhp_pkg;

	// One input word: a file byte and its end-of-file mark.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_t;

	// One result word: a parsed sample header or a status record.
	typedef struct packed {
		logic [1:0]  record_kind;
		logic [31:0] sample_number;
		logic        final_sample;
		logic [1:0]  channel_count;
		logic [31:0] rate_hz;
		logic [31:0] offset_bytes;
		logic [29:0] frame_count;
		logic [31:0] setup_checksum;
		logic [31:0] bank_mode;
	} out_t;

	localparam logic [1:0] KIND_SAMPLE    = 2'd0;
	localparam logic [1:0] KIND_EMPTY     = 2'd1;
	localparam logic [1:0] KIND_BAD_HDR   = 2'd2;
	localparam logic [1:0] KIND_TRUNCATED = 2'd3;

	localparam logic [6:0] HDR_SIZE_V0 = 7'd64;
	localparam logic [6:0] HDR_SIZE    = 7'd60;
	localparam logic [5:0] HDR_EMPTY_MIN = 6'd60;

	localparam logic [6:0] CHUNK_RATE  = 7'd2;
	localparam logic [6:0] CHUNK_SETUP = 7'd11;

	// "FSB5", one byte per position
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		unique case (idx)
			2'd0: m = 8'h46;
			2'd1: m = 8'h53;
			2'd2: m = 8'h42;
			2'd3: m = 8'h35;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	// sample rate code to Hz, 0 for unassigned codes
	function automatic logic [31:0] rate_lookup(input logic [3:0] code);
		logic [31:0] r;
		unique case (code)
			4'd1:  r = 32'd8000;
			4'd2:  r = 32'd11000;
			4'd3:  r = 32'd11025;
			4'd4:  r = 32'd16000;
			4'd5:  r = 32'd22050;
			4'd6:  r = 32'd24000;
			4'd7:  r = 32'd32000;
			4'd8:  r = 32'd44100;
			4'd9:  r = 32'd48000;
			4'd10: r = 32'd96000;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sound_bank_header_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sound-bank header parser. Feed the bank file one byte per word on the byte
// channel, with end_of_file set on the last byte; one record word comes out
// per sample header (with its chained metadata chunks folded in), plus a
// status record for an empty bank, a bad magic or short header, or a file that
// ends inside the sample headers. The block takes one byte every clock cycle:
// each byte is handled by the parse logic between the state
// registers and the record register. A record register plus a one-word skid
// stage decouple the two sides, so bytes keep flowing while a record waits;
// the byte channel stalls only when both hold an untaken record. After the
// end-of-file byte the parser is back in its reset state for the next file.
// Bytes after the last sample header, and after a bad magic, are dropped.
module sound_bank_header_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          byte_valid,
	output logic               byte_ready,
	input  wire sbhp_pkg::in_t byte_data,
	output logic               record_valid,
	input  wire logic          record_ready,
	output sbhp_pkg::out_t     record_data
);

	// parse phases
	localparam logic [2:0] PH_HEADER    = 3'd0;
	localparam logic [2:0] PH_SAMPLE    = 3'd1;
	localparam logic [2:0] PH_CHUNKHDR  = 3'd2;
	localparam logic [2:0] PH_CHUNKBODY = 3'd3;
	localparam logic [2:0] PH_DONE      = 3'd4;
	localparam logic [2:0] PH_ERROR     = 3'd5;

	// parser state
	logic [2:0]  phase_q,   phase_n;
	logic [5:0]  pos_q,     pos_n;
	logic        vzero_q,   vzero_n;   // header version is zero
	logic [31:0] left_q,    left_n;    // sample headers still due
	logic [31:0] mode_q,    mode_n;
	logic [63:0] shift_q,   shift_n;   // last eight bytes, newest on top
	logic [23:0] rem_q,     rem_n;     // chunk body bytes left
	logic [6:0]  ckind_q,   ckind_n;
	logic        more_q,    more_n;
	logic [31:0] count_q,   count_n;   // index of current sample

	// sample under construction
	logic [31:0] p_rate_q,  p_rate_n;
	logic [27:0] p_off_q,   p_off_n;
	logic [29:0] p_frm_q,   p_frm_n;
	logic [31:0] p_crc_q,   p_crc_n;
	logic        p_ch_q,    p_ch_n;

	// output register and skid stage
	logic           out_valid_q, skid_valid_q;
	sbhp_pkg::out_t out_q, skid_q;

	logic           byte_fire, pop, res_valid, fin_sample;
	sbhp_pkg::out_t res;
	logic [31:0]    word;
	logic [6:0]     pos_inc;

	assign byte_ready   = !skid_valid_q;
	assign byte_fire    = byte_valid && byte_ready;
	assign pop          = out_valid_q && record_ready;
	assign record_valid = out_valid_q;
	assign record_data  = out_q;

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		vzero_n   = vzero_q;
		left_n    = left_q;
		mode_n    = mode_q;
		shift_n   = shift_q;
		rem_n     = rem_q;
		ckind_n   = ckind_q;
		more_n    = more_q;
		count_n   = count_q;
		p_rate_n  = p_rate_q;
		p_off_n   = p_off_q;
		p_frm_n   = p_frm_q;
		p_crc_n   = p_crc_q;
		p_ch_n    = p_ch_q;
		res_valid = 1'b0;
		res       = '0;
		fin_sample = 1'b0;
		pos_inc   = {1'b0, pos_q} + 7'd1;

		// done and error phases freeze the shift line
		if (phase_q != PH_DONE && phase_q != PH_ERROR) begin
			shift_n = {byte_data.data_byte, shift_q[63:8]};
		end
		word = shift_n[63:32];

		unique case (phase_q)
			PH_HEADER: begin
				if (pos_q < 6'd4 &&
				    byte_data.data_byte != sbhp_pkg::magic_byte(pos_q[1:0])) begin
					phase_n   = PH_ERROR;
					res_valid = 1'b1;
					res.record_kind = sbhp_pkg::KIND_BAD_HDR;
				end else begin
					if (pos_q == 6'd7)  vzero_n = (word == 32'd0);
					if (pos_q == 6'd11) left_n  = word;
					if (pos_q == 6'd27) mode_n  = word;
					pos_n = pos_inc[5:0];
					if (pos_inc == (vzero_n ? sbhp_pkg::HDR_SIZE_V0 : sbhp_pkg::HDR_SIZE))
					begin
						pos_n = 6'd0;
						if (left_n == 32'd0) begin
							phase_n   = PH_DONE;
							res_valid = 1'b1;
							res.record_kind = sbhp_pkg::KIND_EMPTY;
							res.bank_mode   = mode_n;
						end else begin
							phase_n = PH_SAMPLE;
						end
					end
				end
			end
			PH_SAMPLE: begin
				if (pos_q == 6'd7) begin
					// 8-byte little-endian sample header
					p_rate_n = sbhp_pkg::rate_lookup(shift_n[4:1]);
					p_ch_n   = shift_n[5];
					p_off_n  = shift_n[33:6];
					p_frm_n  = shift_n[63:34];
					p_crc_n  = 32'd0;
					pos_n    = 6'd0;
					if (shift_n[0]) phase_n = PH_CHUNKHDR;
					else            fin_sample = 1'b1;
				end else begin
					pos_n = pos_inc[5:0];
				end
			end
			PH_CHUNKHDR: begin
				if (pos_q == 6'd3) begin
					more_n  = word[0];
					rem_n   = word[24:1];
					ckind_n = word[31:25];
					pos_n   = 6'd0;
					if (rem_n == 24'd0) begin
						if (more_n) phase_n = PH_CHUNKHDR;
						else        fin_sample = 1'b1;
					end else begin
						phase_n = PH_CHUNKBODY;
					end
				end else begin
					pos_n = pos_inc[5:0];
				end
			end
			PH_CHUNKBODY: begin
				// only the first body word matters
				if (pos_q < 6'd4) begin
					pos_n = pos_inc[5:0];
					if (pos_q == 6'd3) begin
						if (ckind_q == sbhp_pkg::CHUNK_SETUP)     p_crc_n  = word;
						else if (ckind_q == sbhp_pkg::CHUNK_RATE) p_rate_n = word;
					end
				end
				rem_n = rem_q - 24'd1;
				if (rem_n == 24'd0) begin
					pos_n = 6'd0;
					if (more_q) phase_n = PH_CHUNKHDR;
					else        fin_sample = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (fin_sample) begin
			res_valid = 1'b1;
			res.record_kind    = sbhp_pkg::KIND_SAMPLE;
			res.sample_number  = count_q;
			res.final_sample   = (left_q == 32'd1);
			res.channel_count  = {1'b0, p_ch_n} + 2'd1;
			res.rate_hz        = p_rate_n;
			res.offset_bytes   = {p_off_n, 4'b0000};
			res.frame_count    = p_frm_n;
			res.setup_checksum = p_crc_n;
			res.bank_mode      = mode_q;
			count_n = count_q + 32'd1;
			left_n  = left_q - 32'd1;
			phase_n = (left_n == 32'd0) ? PH_DONE : PH_SAMPLE;
			pos_n   = 6'd0;
		end

		if (byte_data.end_of_file) begin
			// end-of-file record replaces a sample record of the same byte while samples are still due
			if (phase_n == PH_HEADER) begin
				res_valid = 1'b1;
				res = '0;
				if (vzero_n && left_n == 32'd0 && pos_n >= sbhp_pkg::HDR_EMPTY_MIN) begin
					res.record_kind = sbhp_pkg::KIND_EMPTY;
					res.bank_mode   = mode_n;
				end else begin
					res.record_kind = sbhp_pkg::KIND_BAD_HDR;
				end
			end else if (phase_n == PH_SAMPLE || phase_n == PH_CHUNKHDR ||
			             phase_n == PH_CHUNKBODY) begin
				res_valid = 1'b1;
				res = '0;
				res.record_kind   = sbhp_pkg::KIND_TRUNCATED;
				res.sample_number = count_n;
				res.bank_mode     = mode_n;
			end
			phase_n = PH_HEADER;
			pos_n   = 6'd0;
			vzero_n = 1'b1;
			left_n  = 32'd0;
			mode_n  = 32'd0;
			rem_n   = 24'd0;
			ckind_n = 7'd0;
			more_n  = 1'b0;
			count_n = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 6'd0;
			vzero_q <= 1'b1;
			left_q  <= 32'd0;
			mode_q  <= 32'd0;
			rem_q   <= 24'd0;
			ckind_q <= 7'd0;
			more_q  <= 1'b0;
			count_q <= 32'd0;
		end else if (byte_fire) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			vzero_q <= vzero_n;
			left_q  <= left_n;
			mode_q  <= mode_n;
			rem_q   <= rem_n;
			ckind_q <= ckind_n;
			more_q  <= more_n;
			count_q <= count_n;
		end
	end

	// payload registers, no reset needed: always written before use
	always_ff @(posedge clk) begin
		if (byte_fire) begin
			shift_q  <= shift_n;
			p_rate_q <= p_rate_n;
			p_off_q  <= p_off_n;
			p_frm_q  <= p_frm_n;
			p_crc_q  <= p_crc_n;
			p_ch_q   <= p_ch_n;
		end
	end

	// record register with one-word skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (byte_fire && res_valid) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (byte_fire && res_valid) begin
			if (out_valid_q && !pop) skid_q <= res;
			else                     out_q  <= res;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a record while the output register is empty");

	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		byte_fire && byte_data.end_of_file |=> phase_q == PH_HEADER && pos_q == 6'd0)
		else $error("parser not back at file header after end of file");

	a_idle_no_record: assert property (@(posedge clk) disable iff (!arst_n)
		byte_fire && !byte_data.end_of_file &&
		(phase_q == PH_DONE || phase_q == PH_ERROR) |-> !res_valid)
		else $error("record produced from a finished or failed file");

	a_body_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CHUNKBODY |-> rem_q != 24'd0)
		else $error("chunk body phase with no bytes left");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on either side
	localparam int HOLD_CYCLES    = 300;   // one long receiver hold-off
	localparam int TOTAL_BYTES    = 1100;  // byte words to send over the whole run

	localparam logic [7:0] FILE_MAGIC [4] = '{8'h46, 8'h53, 8'h42, 8'h35};

	// 4-bit rate code from a sample header to Hz; unassigned codes read as 0
	localparam logic [31:0] RATE_BY_CODE [16] = '{
		32'd0, 32'd8000, 32'd11000, 32'd11025, 32'd16000, 32'd22050, 32'd24000, 32'd32000,
		32'd44100, 32'd48000, 32'd96000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
	};

	// where the parser is inside the current file
	typedef enum logic [2:0] {
		ST_HEADER,
		ST_SAMPLE_HDR,
		ST_CHUNK_HDR,
		ST_CHUNK_BODY,
		ST_DONE,
		ST_SKIP
	} bank_stage_t;

	// Follows the byte stream the way the parser should and keeps the records
	// that the block still owes us, oldest first.
	class bank_record_tracker;
		sbhp_pkg::out_t due_records[$];
		int          errors;
		int          kind_seen[4];

		bank_stage_t stage;
		int unsigned idx;           // byte index within header / sample header / chunk
		logic [31:0] bank_version;
		logic [31:0] due;           // sample headers still to come
		logic [31:0] mode_w;
		logic [63:0] window;        // last 8 bytes, newest at the top
		logic [23:0] body_left;
		logic [6:0]  body_kind;
		bit          chain_on;
		logic [31:0] next_index;
		logic [31:0] cur_rate;
		logic [31:0] cur_offset;
		logic [29:0] cur_frames;
		logic [31:0] cur_crc;
		logic [1:0]  cur_chan;

		function new();
			errors = 0;
			kind_seen = '{0, 0, 0, 0};
			clear_state();
		endfunction

		function void clear_state();
			stage = ST_HEADER;
			idx = 0;
			bank_version = '0;
			due = '0;
			mode_w = '0;
			window = '0;
			body_left = '0;
			body_kind = '0;
			chain_on = 0;
			next_index = '0;
			cur_rate = '0;
			cur_offset = '0;
			cur_frames = '0;
			cur_crc = '0;
			cur_chan = '0;
		endfunction

		function sbhp_pkg::out_t status_record(logic [1:0] kind, logic [31:0] num,
				logic [31:0] mode);
			sbhp_pkg::out_t r;
			r = '0;
			r.record_kind = kind;
			r.sample_number = num;
			r.bank_mode = mode;
			return r;
		endfunction

		function sbhp_pkg::out_t close_sample();
			sbhp_pkg::out_t r;
			r = '0;
			r.record_kind = sbhp_pkg::KIND_SAMPLE;
			r.sample_number = next_index;
			r.final_sample = (due == 32'd1);
			r.channel_count = cur_chan;
			r.rate_hz = cur_rate;
			r.offset_bytes = cur_offset;
			r.frame_count = cur_frames;
			r.setup_checksum = cur_crc;
			r.bank_mode = mode_w;
			next_index++;
			due--;
			stage = (due == 0) ? ST_DONE : ST_SAMPLE_HDR;
			idx = 0;
			return r;
		endfunction

		// a chunk is over: either another chunk header follows or the sample is done
		function bit close_chunk(output sbhp_pkg::out_t r);
			idx = 0;
			r = '0;
			if (chain_on) begin
				stage = ST_CHUNK_HDR;
				return 0;
			end
			r = close_sample();
			return 1;
		endfunction

		function void note_byte(sbhp_pkg::in_t w);
			logic [7:0]  b;
			logic [31:0] word;
			int unsigned pos;
			sbhp_pkg::out_t rec;
			bit          have;
			b = w.data_byte;
			have = 0;
			rec = '0;
			if (stage != ST_DONE && stage != ST_SKIP)
				window = {b, window[63:8]};
			word = window[63:32];

			case (stage)
				ST_HEADER: begin
					pos = idx;
					if (pos < 4 && b != FILE_MAGIC[pos]) begin
						// wrong magic: report now, swallow the rest of the file
						stage = ST_SKIP;
						rec = status_record(sbhp_pkg::KIND_BAD_HDR, '0, '0);
						have = 1;
					end else begin
						if (pos == 7) bank_version = word;
						if (pos == 11) due = word;
						if (pos == 27) mode_w = word;
						idx = (pos + 1) & 63;
						if (pos + 1 == ((bank_version == 0) ? sbhp_pkg::HDR_SIZE_V0 :
								sbhp_pkg::HDR_SIZE)) begin
							idx = 0;
							if (due == 0) begin
								stage = ST_DONE;
								rec = status_record(sbhp_pkg::KIND_EMPTY, '0, mode_w);
								have = 1;
							end else begin
								stage = ST_SAMPLE_HDR;
							end
						end
					end
				end
				ST_SAMPLE_HDR: begin
					if (idx == 7) begin
						cur_rate = RATE_BY_CODE[window[4:1]];
						cur_chan = {1'b0, window[5]} + 2'd1;
						cur_offset = {window[33:6], 4'b0000};
						cur_frames = window[63:34];
						cur_crc = '0;
						idx = 0;
						if (window[0]) begin
							stage = ST_CHUNK_HDR;
						end else begin
							rec = close_sample();
							have = 1;
						end
					end else begin
						idx++;
					end
				end
				ST_CHUNK_HDR: begin
					if (idx == 3) begin
						chain_on = word[0];
						body_left = word[24:1];
						body_kind = word[31:25];
						idx = 0;
						if (body_left == 0)
							have = close_chunk(rec);
						else
							stage = ST_CHUNK_BODY;
					end else begin
						idx++;
					end
				end
				ST_CHUNK_BODY: begin
					// only the first body word matters, and only for rate and setup chunks
					if (idx < 4) begin
						idx++;
						if (idx == 4) begin
							if (body_kind == sbhp_pkg::CHUNK_SETUP)
								cur_crc = word;
							else if (body_kind == sbhp_pkg::CHUNK_RATE)
								cur_rate = word;
						end
					end
					body_left = body_left - 24'd1;
					if (body_left == 0)
						have = close_chunk(rec);
				end
				default: begin
				end
			endcase

			if (w.end_of_file) begin
				// the end-of-file status overrides anything produced by this byte, unless the file is done or skipped
				if (stage == ST_HEADER) begin
					if (bank_version == 0 && due == 0 && idx >= sbhp_pkg::HDR_EMPTY_MIN)
						rec = status_record(sbhp_pkg::KIND_EMPTY, '0, mode_w);
					else
						rec = status_record(sbhp_pkg::KIND_BAD_HDR, '0, '0);
					have = 1;
				end else if (stage == ST_SAMPLE_HDR || stage == ST_CHUNK_HDR ||
						stage == ST_CHUNK_BODY) begin
					rec = status_record(sbhp_pkg::KIND_TRUNCATED, next_index, mode_w);
					have = 1;
				end
				clear_state();
			end
			if (have)
				due_records = {due_records, rec};
		endfunction

		function void flag_field(string field, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t ns: mismatch in %s, expected %h, actual %h", $time, field, want, got);
		endfunction

		function void check_record(sbhp_pkg::out_t got);
			sbhp_pkg::out_t want;
			if (due_records.size() == 0) begin
				errors++;
				$display("%0t ns: record word with nothing expected, actual %h", $time, got);
				return;
			end
			want = due_records.pop_front();
			kind_seen[want.record_kind]++;
			if (got.record_kind !== want.record_kind)
				flag_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
			if (got.sample_number !== want.sample_number)
				flag_field("sample_number", want.sample_number, got.sample_number);
			if (got.final_sample !== want.final_sample)
				flag_field("final_sample", 32'(want.final_sample), 32'(got.final_sample));
			if (got.channel_count !== want.channel_count)
				flag_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
			if (got.rate_hz !== want.rate_hz)
				flag_field("rate_hz", want.rate_hz, got.rate_hz);
			if (got.offset_bytes !== want.offset_bytes)
				flag_field("offset_bytes", want.offset_bytes, got.offset_bytes);
			if (got.frame_count !== want.frame_count)
				flag_field("frame_count", 32'(want.frame_count), 32'(got.frame_count));
			if (got.setup_checksum !== want.setup_checksum)
				flag_field("setup_checksum", want.setup_checksum, got.setup_checksum);
			if (got.bank_mode !== want.bank_mode)
				flag_field("bank_mode", want.bank_mode, got.bank_mode);
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  byte_valid;
	logic  byte_ready;
	sbhp_pkg::in_t  byte_data;
	logic  record_valid;
	logic  record_ready;
	sbhp_pkg::out_t record_data;

	bank_record_tracker tracker;

	logic [7:0] bank_file[$];    // file being built, sent front to back
	int         burst_left;
	int         bytes_sent;
	int         files_sent;
	int         holds_done;
	int         quiet_cycles;
	bit         hold_request;    // stimulus asks the receiver for one long hold-off

	sound_bank_header_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_data    (byte_data),
		.record_valid (record_valid),
		.record_ready (record_ready),
		.record_data  (record_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// File building. Everything is little-endian, as the parser expects.
	// ---------------------------------------------------------------------

	function void add_byte(logic [7:0] b);
		bank_file = {bank_file, b};
	endfunction

	function void add_word(logic [31:0] v);
		for (int i = 0; i < 4; i++)
			bank_file = {bank_file, v[8*i +: 8]};
	endfunction

	// magic, version, sample count, mode word at 24..27, random filler up to
	// 64 bytes for version 0 and 60 bytes otherwise
	function void add_header(logic [31:0] ver, logic [31:0] count, logic [31:0] mode);
		int unsigned hsize;
		hsize = (ver == 0) ? sbhp_pkg::HDR_SIZE_V0 : sbhp_pkg::HDR_SIZE;
		bank_file.delete();
		foreach (FILE_MAGIC[i])
			add_byte(FILE_MAGIC[i]);
		add_word(ver);
		add_word(count);
		repeat (12) add_byte(8'($urandom));
		add_word(mode);
		while (bank_file.size() < hsize)
			add_byte(8'($urandom));
	endfunction

	// 8-byte sample header: continuation, rate code, channels-1, offset/16, frames
	function void add_sample(bit cont, logic [3:0] code, bit chan, logic [27:0] off,
			logic [29:0] frames);
		logic [63:0] h;
		h = {frames, off, chan, code, cont};
		add_word(h[31:0]);
		add_word(h[63:32]);
	endfunction

	// 4-byte chunk header plus a number of random body bytes
	function void add_chunk(bit more, logic [23:0] nbytes, logic [6:0] kind, int unsigned body);
		add_word({kind, nbytes, more});
		repeat (body) add_byte(8'($urandom));
	endfunction

	function void cut_file(int unsigned keep);
		while (bank_file.size() > keep)
			void'(bank_file.pop_back());
	endfunction

	// random sample header, with a random chain of chunks when the flag is set
	function void add_random_sample();
		bit          cont;
		int unsigned n_chunks;
		int unsigned body;
		logic [23:0] nbytes;
		logic [6:0]  kind;
		cont = ($urandom_range(0, 9) < 4);
		add_sample(cont, 4'($urandom), 1'($urandom), 28'($urandom), 30'($urandom));
		if (!cont)
			return;
		n_chunks = $urandom_range(1, 3);
		for (int j = 0; j < n_chunks; j++) begin
			case ($urandom_range(0, 3))
				0: kind = sbhp_pkg::CHUNK_RATE;
				1: kind = sbhp_pkg::CHUNK_SETUP;
				2: kind = 7'($urandom);
				default: kind = 7'd0;
			endcase
			case ($urandom_range(0, 6))
				0: nbytes = 24'd0;
				1: nbytes = 24'($urandom_range(1, 3));
				2, 3: nbytes = 24'd4;
				4: nbytes = 24'($urandom_range(5, 20));
				5: nbytes = 24'd8;
				// oversized now and then: the following bytes vanish into the chunk
				default: nbytes = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'd12;
			endcase
			body = (nbytes <= 24) ? nbytes : $urandom_range(0, 24);
			add_chunk(j < n_chunks - 1, nbytes, kind, body);
		end
	endfunction

	function void build_random_bank();
		int unsigned style;
		int unsigned pick;
		int unsigned n_build;
		logic [31:0] ver;
		logic [31:0] count;
		style = $urandom_range(0, 99);
		if (style < 8) begin
			// noise, sometimes with a plausible first byte
			bank_file.delete();
			repeat ($urandom_range(1, 70)) add_byte(8'($urandom));
			if ($urandom_range(0, 1))
				bank_file[0] = FILE_MAGIC[0];
			return;
		end
		pick = $urandom_range(0, 2);
		ver = (pick == 0) ? 32'd0 : ((pick == 1) ? 32'd1 : 32'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 5)
			count = 32'd0;
		else if (pick < 8)
			count = $urandom;
		else
			count = $urandom_range(1, 6);
		add_header(ver, count, $urandom);
		if (style < 13)
			bank_file[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
		// a huge count only gets a few headers; the file then ends early
		n_build = (count > 8) ? $urandom_range(1, 4) : count;
		repeat (n_build) add_random_sample();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
		if ($urandom_range(0, 6) == 0)
			cut_file($urandom_range(1, bank_file.size()));
	endfunction

	// ---------------------------------------------------------------------
	// Byte channel driver. Drive on the falling edge, accept on the rising.
	// ---------------------------------------------------------------------

	task automatic put_byte(sbhp_pkg::in_t w);
		@(negedge clk);
		byte_valid <= 1'b1;
		byte_data <= w;
		do
			@(posedge clk);
		while (!byte_ready);
	endtask

	task automatic pause_sender(int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			byte_valid <= 1'b0;
		end
	endtask

	// sends bank_file with end_of_file on the last byte; with gaps the bytes go
	// out in bursts of random length separated by short idle stretches
	task automatic feed_bank(bit with_gaps);
		sbhp_pkg::in_t w;
		foreach (bank_file[i]) begin
			if (with_gaps && burst_left <= 0) begin
				pause_sender($urandom_range(1, 7));
				burst_left = $urandom_range(1, 40);
			end
			w.data_byte = bank_file[i];
			w.end_of_file = (i == bank_file.size() - 1);
			put_byte(w);
			burst_left--;
			bytes_sent++;
		end
		files_sent++;
	endtask

	// ---------------------------------------------------------------------
	// Record channel: the receiver switches among random stall patterns, and on
	// request holds off for one long stretch so that the skid stage fills and the
	// byte channel has to stall.
	// ---------------------------------------------------------------------

	initial begin
		int unsigned style;
		int unsigned stretch;
		int unsigned tick;
		int unsigned cyc;
		int          hold_left;
		record_ready = 1'b0;
		style = 0;
		stretch = 100;
		tick = 0;
		cyc = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_left > 0) begin
				record_ready <= 1'b0;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES - 1;
				holds_done++;
				record_ready <= 1'b0;
			end else begin
				case (style)
					0: record_ready <= 1'b1;
					1: record_ready <= 1'($urandom_range(0, 1));
					2: record_ready <= (cyc % 4 == 0);
					default: record_ready <= ($urandom_range(0, 7) != 0);
				endcase
				tick++;
				if (tick >= stretch) begin
					tick = 0;
					style = $urandom_range(0, 3);
					stretch = $urandom_range(50, 300);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor and watchdog, both on the rising edge.
	// ---------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && byte_ready)
				tracker.note_byte(byte_data);
			if (record_valid && record_ready)
				tracker.check_record(record_data);
			if ((byte_valid && byte_ready) || (record_valid && record_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t ns: no word moved for %0d cycles, %0d records outstanding",
						$time, quiet_cycles, tracker.due_records.size());
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		burst_left = 0;
		bytes_sent = 0;
		files_sent = 0;
		holds_done = 0;
		quiet_cycles = 0;
		hold_request = 0;
		tracker = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// version 0 header: one sample with every field at zero, then two with
		// all fields at their top values, junk after the last sample
		add_header(32'd0, 32'd3, 32'hFFFF_FFFF);
		add_sample(0, 4'd0, 0, 28'd0, 30'd0);
		add_sample(0, 4'hF, 1, 28'hFFF_FFFF, 30'h3FFF_FFFF);
		add_sample(0, 4'hF, 1, 28'hFFF_FFFF, 30'h3FFF_FFFF);
		repeat (5) add_byte(8'hFF);
		feed_bank(1);

		// every rate code, both channel settings, sent without gaps while the
		// receiver holds off: the output side fills up and the byte channel
		// must stall
		hold_request = 1;
		add_header(32'd7, 32'd16, $urandom);
		for (int c = 0; c < 16; c++)
			add_sample(0, 4'(c), c[0], 28'($urandom), 30'($urandom));
		feed_bank(0);

		// chunk chains: rate override, setup CRC with a longer body, an unknown
		// kind, a zero-length chunk, a rate chunk too short to override, and a
		// zero-length last chunk
		add_header(32'd1, 32'd3, $urandom);
		add_sample(1, 4'd8, 1, 28'($urandom), 30'($urandom));
		add_chunk(1, 24'd4, sbhp_pkg::CHUNK_RATE, 0);
		add_word(32'd12345);
		add_chunk(1, 24'd9, sbhp_pkg::CHUNK_SETUP, 0);
		add_word(32'hDEAD_BEEF);
		repeat (5) add_byte(8'($urandom));
		add_chunk(0, 24'd6, 7'h7F, 6);
		add_sample(1, 4'd3, 0, 28'($urandom), 30'($urandom));
		add_chunk(1, 24'd0, sbhp_pkg::CHUNK_SETUP, 0);
		add_chunk(1, 24'd3, sbhp_pkg::CHUNK_RATE, 3);
		add_chunk(0, 24'd4, 7'd0, 4);
		add_sample(1, 4'd5, 1, 28'($urandom), 30'($urandom));
		add_chunk(0, 24'd0, sbhp_pkg::CHUNK_RATE, 0);
		feed_bank(0);

		// empty bank, bytes after the header are dropped
		add_header(32'd1, 32'd0, $urandom);
		repeat (9) add_byte(8'($urandom));
		feed_bank(1);

		// version 0 empty bank ended at 60 bytes (still empty) and at 59 bytes
		// (short header)
		add_header(32'd0, 32'd0, $urandom);
		cut_file(60);
		feed_bank(1);
		add_header(32'd0, 32'd0, $urandom);
		cut_file(59);
		feed_bank(1);

		// bad magic at each of the four positions, with more bytes after it
		for (int p = 0; p < 4; p++) begin
			add_header(32'd1, 32'd1, $urandom);
			bank_file[p] = ~FILE_MAGIC[p];
			cut_file(8);
			feed_bank(1);
		end

		// short header, and one-byte files with and without a good first byte
		add_header(32'd1, 32'd2, $urandom);
		cut_file(30);
		feed_bank(1);
		bank_file.delete();
		add_byte(FILE_MAGIC[0]);
		feed_bank(1);
		bank_file.delete();
		add_byte(8'h00);
		feed_bank(1);

		// ends inside a sample header and inside a chunk header
		add_header(32'd1, 32'd2, $urandom);
		add_sample(0, 4'd1, 0, 28'($urandom), 30'($urandom));
		repeat (3) add_byte(8'($urandom));
		feed_bank(1);
		add_header(32'd1, 32'd1, $urandom);
		add_sample(1, 4'd2, 1, 28'($urandom), 30'($urandom));
		repeat (2) add_byte(8'($urandom));
		feed_bank(1);

		// oversized chunk that runs past the end of the file
		add_header(32'd1, 32'd2, $urandom);
		add_sample(1, 4'd10, 1, 28'($urandom), 30'($urandom));
		add_chunk(0, 24'hFF_FFFF, sbhp_pkg::CHUNK_SETUP, 10);
		feed_bank(1);

		// the end-of-file byte completes a sample while more are due: only the
		// truncated record must come out for it
		add_header(32'd1, 32'd3, $urandom);
		add_sample(0, 4'd4, 0, 28'($urandom), 30'($urandom));
		add_sample(0, 4'd6, 1, 28'($urandom), 30'($urandom));
		feed_bank(1);

		// random part: mostly well-formed banks with random contents, until the
		// byte budget of the run is used up
		while (bytes_sent < TOTAL_BYTES) begin
			build_random_bank();
			feed_bank($urandom_range(0, 3) != 0);
		end
		pause_sender(1);

		while (tracker.due_records.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("%0d bank files, %0d bytes parsed, %0d long receiver hold-offs",
			files_sent, bytes_sent, holds_done);
		$display("records checked: %0d sample, %0d empty, %0d bad header, %0d truncated",
			tracker.kind_seen[0], tracker.kind_seen[1], tracker.kind_seen[2],
			tracker.kind_seen[3]);
		if (tracker.errors == 0 && tracker.due_records.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d records never seen", tracker.errors,
				tracker.due_records.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule
